// File: sv/rtt_pkg.sv
// ----------------------------------------------------------------------------
// rtt_pkg
// Shared types and constants for the real-time timer register block.
// ----------------------------------------------------------------------------
package rtt_pkg;

    localparam int unsigned PRESCALE_BITS_DEF = 16;
    localparam int unsigned DATA_W            = 32;
    localparam int unsigned DIV_W             = 16;

    localparam logic [DATA_W-1:0] MODE_RESET  = 32'h0000_8000;
    localparam logic [DATA_W-1:0] ALARM_RESET = 32'hFFFF_FFFF;
    localparam logic [DIV_W-1:0]  SLOW_DIV    = 16'h8000;

    localparam int unsigned MODE_ALM_EN_BIT = 16;
    localparam int unsigned MODE_INC_EN_BIT = 17;
    localparam int unsigned MODE_RESTART_BIT = 18;

    localparam int unsigned FLAG_ALARM_BIT = 0;
    localparam int unsigned FLAG_INC_BIT   = 1;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_WRITE = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        REG_MODE   = 2'd0,
        REG_ALARM  = 2'd1,
        REG_VALUE  = 2'd2,
        REG_STATUS = 2'd3
    } t_reg_index;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [1:0]        reg_index;
        logic [DATA_W-1:0] write_data;
    } t_item;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              irq_level;
        logic              access_error;
    } t_result;

endpackage

// File: sv/rtt_exec.sv
// ----------------------------------------------------------------------------
// rtt_exec
// Timer state registers and the combinational execute logic for one word.
// ----------------------------------------------------------------------------
module rtt_exec #(
    parameter int unsigned PRESCALE_BITS = rtt_pkg::PRESCALE_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  rtt_pkg::t_item  i_item,
    output rtt_pkg::t_result o_result
);
    import rtt_pkg::*;

    localparam logic [DIV_W-1:0] DIV_MASK = DIV_W'((32'd1 << PRESCALE_BITS) - 32'd1);

    logic [DATA_W-1:0] r_mode_word, n_mode_word;
    logic [DATA_W-1:0] r_alarm_word, n_alarm_word;
    logic [DATA_W-1:0] r_time_value, n_time_value;
    logic [1:0]        r_status_flags, n_status_flags;
    logic [DIV_W-1:0]  r_active_divisor, n_active_divisor;
    logic [DIV_W-1:0]  r_prescale_count, n_prescale_count;

    logic [DIV_W-1:0]  count_inc;
    logic [DIV_W-1:0]  div_field;
    logic              bump;
    logic [DATA_W-1:0] rd;
    logic              err;

    assign count_inc = r_prescale_count + DIV_W'(1);
    assign bump      = (count_inc >= r_active_divisor) || (r_prescale_count >= r_active_divisor);
    assign div_field = i_item.write_data[DIV_W-1:0] & DIV_MASK;

    always_comb begin
        n_mode_word      = r_mode_word;
        n_alarm_word     = r_alarm_word;
        n_time_value     = r_time_value;
        n_status_flags   = r_status_flags;
        n_active_divisor = r_active_divisor;
        n_prescale_count = r_prescale_count;
        rd               = '0;
        err              = 1'b0;
        unique case (t_cmd'(i_item.cmd))
            CMD_TICK: begin
                if (bump) begin
                    n_prescale_count             = '0;
                    n_time_value                 = r_time_value + DATA_W'(1);
                    n_status_flags[FLAG_INC_BIT] = 1'b1;
                    // value+1 == alarm+1 under wrap
                    if (r_time_value == r_alarm_word) begin
                        n_status_flags[FLAG_ALARM_BIT] = 1'b1;
                    end
                end else begin
                    n_prescale_count = count_inc;
                end
            end
            CMD_READ: begin
                unique case (t_reg_index'(i_item.reg_index))
                    REG_MODE:  rd = r_mode_word;
                    REG_ALARM: rd = r_alarm_word;
                    REG_VALUE: rd = r_time_value;
                    REG_STATUS: begin
                        rd             = {{(DATA_W-2){1'b0}}, r_status_flags};
                        n_status_flags = '0;
                    end
                    default: rd = '0;
                endcase
            end
            CMD_WRITE: begin
                unique case (t_reg_index'(i_item.reg_index))
                    REG_MODE: begin
                        n_mode_word = i_item.write_data;
                        if (i_item.write_data[MODE_RESTART_BIT]) begin
                            n_time_value     = '0;
                            n_prescale_count = '0;
                            n_active_divisor = (div_field == '0) ? SLOW_DIV : div_field;
                        end
                    end
                    REG_ALARM: n_alarm_word = i_item.write_data;
                    default:   err = 1'b1;
                endcase
            end
            default: begin
            end
        endcase
    end

    assign o_result.read_data    = rd;
    assign o_result.access_error = err;
    assign o_result.irq_level    =
        |({n_mode_word[MODE_INC_EN_BIT], n_mode_word[MODE_ALM_EN_BIT]} & n_status_flags);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_word      <= MODE_RESET;
            r_alarm_word     <= ALARM_RESET;
            r_time_value     <= '0;
            r_status_flags   <= '0;
            r_active_divisor <= SLOW_DIV;
            r_prescale_count <= '0;
        end else if (i_fire) begin
            r_mode_word      <= n_mode_word;
            r_alarm_word     <= n_alarm_word;
            r_time_value     <= n_time_value;
            r_status_flags   <= n_status_flags;
            r_active_divisor <= n_active_divisor;
            r_prescale_count <= n_prescale_count;
        end
    end

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active_divisor != '0)
        else $error("active divisor is zero");

    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_item.cmd == CMD_WRITE && i_item.reg_index == REG_MODE
            && i_item.write_data[MODE_RESTART_BIT]
        |=> r_time_value == '0 && r_prescale_count == '0)
        else $error("restart did not clear value and prescaler");

    a_status_read_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_item.cmd == CMD_READ && i_item.reg_index == REG_STATUS
        |=> r_status_flags == '0)
        else $error("status read did not clear flags");

    a_illegal_write_no_effect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_item.cmd == CMD_WRITE
            && (i_item.reg_index == REG_VALUE || i_item.reg_index == REG_STATUS)
        |=> $stable(r_mode_word) && $stable(r_alarm_word) && $stable(r_time_value)
            && $stable(r_status_flags))
        else $error("illegal write changed state");

endmodule

// File: sv/real_time_timer_registers.sv
// ----------------------------------------------------------------------------
// real_time_timer_registers
// Real-time timer with mode, alarm, value and status registers.
// ----------------------------------------------------------------------------
// flow: a word waits in the input register, and its result in the output register
// throughput: one word per cycle while the output is taken, set by the single execute stage on the state
// input ready follows output ready through the execute stage when both are full
// reset: synchronous active low; mode 0x8000, alarm all ones, value, status and
// prescaler zero, divisor 32768, both pipeline stages empty
module real_time_timer_registers #(
    parameter int unsigned PRESCALE_BITS = rtt_pkg::PRESCALE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [1:0]                  i_cmd,
    input  logic [1:0]                  i_reg_index,
    input  logic [rtt_pkg::DATA_W-1:0]  i_write_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [rtt_pkg::DATA_W-1:0]  o_read_data,
    output logic                        o_irq_level,
    output logic                        o_access_error
);
    import rtt_pkg::*;

    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_result;
    t_result exec_result;
    logic    fire;

    assign fire       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item.cmd        <= i_cmd;
            r_item.reg_index  <= i_reg_index;
            r_item.write_data <= i_write_data;
        end
    end

    rtt_exec #(
        .PRESCALE_BITS(PRESCALE_BITS)
    ) u_exec (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_item),
        .o_result (exec_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_result <= exec_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_read_data    = r_result.read_data;
    assign o_irq_level    = r_result.irq_level;
    assign o_access_error = r_result.access_error;

endmodule
